/* rtl/pcm_pkg.sv */
// Package for the pairwise contact map unit: widths, register indexes, sequencer states.
`default_nettype none
package pcm_pkg;

  localparam int MAX_ATOMS_DEF  = 64;
  localparam int COORD_BITS_DEF = 24;

  localparam int COUNT_BITS  = 7;
  localparam int CUT_BITS    = 52;
  localparam int BOX_BITS    = 23;
  localparam int SKIP_BITS   = 16;
  localparam int CFG_BITS    = 52;
  localparam int CFG_IDX_BITS = 2;

  localparam int ROW_BITS      = 63;
  localparam int ATOM_IDX_BITS = 6;

  localparam logic [CFG_IDX_BITS-1:0] REG_ATOM_COUNT = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CUTOFF_SQ  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_BOX_LENGTH = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAME_SKIP = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_AXIS,
    S_DIV,
    S_FOLD,
    S_SQ,
    S_ACC,
    S_CMP,
    S_OUT
  } state_t;

endpackage
`default_nettype wire

/* rtl/pairwise_contact_map_unit.sv */
// Pairwise contact map unit: top level with coordinate store and shared pair sequencer.
`default_nettype none

// Atoms arrive one beat at a time; each beat is stored and, in a selected frame, compared
// against every earlier atom of the frame. in_ready is high only while the sequencer is
// idle. An atom with index i in a selected frame is paired with each of its i earlier
// atoms in turn: each axis difference is squared and summed, and the sum is compared
// with the cutoff. With a box length set, each axis first runs a restoring remainder,
// one bit per cycle, through the one shared divide/square/accumulate unit. The first
// atom of a frame and atoms of unselected frames yield no row. A finished row sits in
// the output register until taken, so the next beat can be accepted meanwhile; a new
// row waits for that register to empty. Configuration writes (cfg_we) take effect at
// once and should only be made while the block is idle.
module pairwise_contact_map_unit
  import pcm_pkg::*;
#(
  parameter int MAX_ATOMS  = MAX_ATOMS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          cfg_we,
  input  wire  [CFG_IDX_BITS-1:0]      cfg_index,
  input  wire  [CFG_BITS-1:0]          cfg_data,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire  signed [COORD_BITS-1:0] pos_x,
  input  wire  signed [COORD_BITS-1:0] pos_y,
  input  wire  signed [COORD_BITS-1:0] pos_z,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [ROW_BITS-1:0]          contact_bits,
  output logic [ATOM_IDX_BITS-1:0]     atom_index,
  output logic                         last_of_frame
);

  localparam int IDX_BITS  = $clog2(MAX_ATOMS);
  localparam int DIFF_BITS = COORD_BITS + 1;
  localparam int WRAP_BITS = (COORD_BITS > BOX_BITS) ? COORD_BITS : BOX_BITS;
  localparam int SQ_BITS   = 2 * WRAP_BITS;
  localparam int SUM_BITS  = SQ_BITS + 2;
  localparam int CMP_BITS  = (SUM_BITS > CUT_BITS) ? SUM_BITS : CUT_BITS;
  localparam int CNT_BITS  = $clog2(COORD_BITS + 1);

  // configuration registers
  logic [COUNT_BITS-1:0] atom_count;
  logic [CUT_BITS-1:0]   cutoff_squared;
  logic [BOX_BITS-1:0]   box_length;
  logic [SKIP_BITS-1:0]  frame_skip;

  always_ff @(posedge clk) begin
    if (rst) begin
      atom_count     <= COUNT_BITS'(64);
      cutoff_squared <= CUT_BITS'(2359296);
      box_length     <= '0;
      frame_skip     <= SKIP_BITS'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ATOM_COUNT: atom_count     <= cfg_data[COUNT_BITS-1:0];
        REG_CUTOFF_SQ:  cutoff_squared <= cfg_data[CUT_BITS-1:0];
        REG_BOX_LENGTH: box_length     <= cfg_data[BOX_BITS-1:0];
        REG_FRAME_SKIP: frame_skip     <= cfg_data[SKIP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // coordinate store, one array per axis
  logic [COORD_BITS-1:0] mem_x [MAX_ATOMS];
  logic [COORD_BITS-1:0] mem_y [MAX_ATOMS];
  logic [COORD_BITS-1:0] mem_z [MAX_ATOMS];
  logic [COORD_BITS-1:0] rd_x, rd_y, rd_z;

  state_t state, state_next;

  logic [IDX_BITS-1:0]  atom_counter;
  logic [SKIP_BITS-1:0] frame_phase;
  logic [IDX_BITS-1:0]  cur_idx;
  logic                 cur_last;
  logic [IDX_BITS-1:0]  pair_idx;
  logic [1:0]           axis;
  logic [COORD_BITS-1:0] cur_x, cur_y, cur_z;
  logic [COORD_BITS-1:0] dividend;
  logic [BOX_BITS-1:0]  rem;
  logic [CNT_BITS-1:0]  bit_cnt;
  logic [WRAP_BITS-1:0] wrapped;
  logic [SQ_BITS-1:0]   sq;
  logic [SUM_BITS-1:0]  sum;
  logic [ROW_BITS-1:0]  row_bits;

  // beat acceptance decode
  logic                  accept;
  logic [COUNT_BITS-1:0] n_eff;
  logic [SKIP_BITS-1:0]  skip_eff;
  logic                  selected;
  logic                  is_last;
  logic                  needs_work;
  logic                  out_load;
  logic                  pair_done;

  always_comb begin
    if (atom_count < COUNT_BITS'(2)) n_eff = COUNT_BITS'(2);
    else if (atom_count > COUNT_BITS'(MAX_ATOMS)) n_eff = COUNT_BITS'(MAX_ATOMS);
    else n_eff = atom_count;
    skip_eff   = (frame_skip == '0) ? SKIP_BITS'(1) : frame_skip;
    selected   = ({1'b0, frame_phase} + (SKIP_BITS+1)'(1)) >= {1'b0, skip_eff};
    is_last    = (COUNT_BITS'(atom_counter) + COUNT_BITS'(1)) >= n_eff;
    needs_work = selected && (atom_counter != '0);
    pair_done  = ({1'b0, pair_idx} + (IDX_BITS+1)'(1)) == {1'b0, cur_idx};
  end

  // sequencer outputs
  always_comb begin
    in_ready = (state == S_IDLE);
    accept   = in_valid && in_ready;
    out_load = (state == S_OUT) && (!out_valid || out_ready);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept && needs_work) state_next = S_READ;
      S_READ: state_next = S_AXIS;
      S_AXIS: state_next = (box_length == '0) ? S_SQ : S_DIV;
      S_DIV:  if (bit_cnt == CNT_BITS'(1)) state_next = S_FOLD;
      S_FOLD: state_next = S_SQ;
      S_SQ:   state_next = S_ACC;
      S_ACC:  state_next = (axis == 2'd2) ? S_CMP : S_AXIS;
      S_CMP:  state_next = pair_done ? S_OUT : S_READ;
      S_OUT:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      atom_counter <= '0;
      frame_phase  <= '0;
    end else if (accept) begin
      if (is_last) begin
        atom_counter <= '0;
        frame_phase  <= selected ? '0 : frame_phase + SKIP_BITS'(1);
      end else begin
        atom_counter <= atom_counter + IDX_BITS'(1);
      end
    end
  end

  // store write and registered read
  always_ff @(posedge clk) begin
    if (accept) begin
      mem_x[atom_counter] <= pos_x;
      mem_y[atom_counter] <= pos_y;
      mem_z[atom_counter] <= pos_z;
    end
    if (state == S_READ) begin
      rd_x <= mem_x[pair_idx];
      rd_y <= mem_y[pair_idx];
      rd_z <= mem_z[pair_idx];
    end
  end

  // axis operand select and magnitude of the difference
  logic [COORD_BITS-1:0] op_a, op_b;
  logic [DIFF_BITS-1:0]  diff;
  logic [COORD_BITS-1:0] mag;
  logic [BOX_BITS:0]     trial;
  logic [BOX_BITS:0]     trial_sub;

  always_comb begin
    case (axis)
      2'd0:    begin op_a = cur_x; op_b = rd_x; end
      2'd1:    begin op_a = cur_y; op_b = rd_y; end
      default: begin op_a = cur_z; op_b = rd_z; end
    endcase
    diff      = {op_a[COORD_BITS-1], op_a} - {op_b[COORD_BITS-1], op_b};
    mag       = diff[DIFF_BITS-1] ? COORD_BITS'(-diff) : COORD_BITS'(diff);
    trial     = {rem, dividend[COORD_BITS-1]};
    trial_sub = trial - {1'b0, box_length};
  end

  // shared pair datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          cur_x    <= pos_x;
          cur_y    <= pos_y;
          cur_z    <= pos_z;
          cur_idx  <= atom_counter;
          cur_last <= is_last;
          pair_idx <= '0;
          row_bits <= '0;
        end
        axis <= '0;
        sum  <= '0;
      end
      S_AXIS: begin
        dividend <= mag;
        rem      <= '0;
        bit_cnt  <= CNT_BITS'(COORD_BITS);
        wrapped  <= WRAP_BITS'(mag);
      end
      S_DIV: begin
        // restoring remainder, one dividend bit per cycle
        rem      <= (trial >= {1'b0, box_length}) ? BOX_BITS'(trial_sub) : BOX_BITS'(trial);
        dividend <= dividend << 1;
        bit_cnt  <= bit_cnt - CNT_BITS'(1);
      end
      S_FOLD: begin
        // nearest image: distance to the closer multiple of the box
        wrapped <= ({rem, 1'b0} >= {1'b0, box_length}) ? WRAP_BITS'(box_length - rem)
                                                       : WRAP_BITS'(rem);
      end
      S_SQ: sq <= wrapped * wrapped;
      S_ACC: begin
        sum  <= sum + SUM_BITS'(sq);
        axis <= axis + 2'd1;
      end
      S_CMP: begin
        if (CMP_BITS'(sum) < CMP_BITS'(cutoff_squared))
          row_bits[ATOM_IDX_BITS'(pair_idx)] <= 1'b1;
        pair_idx <= pair_idx + IDX_BITS'(1);
        axis     <= '0;
        sum      <= '0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      contact_bits  <= row_bits;
      atom_index    <= ATOM_IDX_BITS'(cur_idx);
      last_of_frame <= cur_last;
    end
  end

endmodule
`default_nettype wire
